>>> sv/adrs_pkg.sv
// Shared constants for the mono downmix and rate converter block.
package adrs_pkg;

  // Sample format codes
  localparam logic [1:0] FMT_FLOAT32 = 2'd0;
  localparam logic [1:0] FMT_INT16   = 2'd1;
  localparam logic [1:0] FMT_INT32   = 2'd2;
  localparam logic [1:0] FMT_BAD     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_IN_RATE  = 2'd2;
  localparam logic [1:0] REG_TGT_RATE = 2'd3;

  // Field and datapath widths
  localparam int RATE_W = 19;
  localparam int DIV_W  = 20;
  localparam int PCM_W  = 16;
  localparam logic [PCM_W-1:0] PCM_MAX = 16'd32767;

  // Divider modes
  typedef enum logic {DIV_PCM, DIV_RATE} div_mode_t;

endpackage

>>> sv/audio_downmix_resample_pcm16_top.sv
// Mono downmix, 16-bit scaling and drop/repeat rate converter.
// A frame-closing item is accumulated, scaled and put through two bit-serial 20-step divides
// (the mean, then the phase); a silent item goes through the phase divide only, and with both
// rates zero no phase divide runs. A new item is accepted only once all results of the last
// one have been sent.
// Reset (synchronous, active low) clears phase, frame sum, channel index, error flag.
module audio_downmix_resample_pcm16_top #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_REPEATS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [18:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_word
  input  logic        in_tuser,   // [0] silent
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] pcm_sample
  output logic        out_tuser,  // [0] error
  output logic        out_tlast
);
  import adrs_pkg::*;

  localparam int IW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SW  = 33 + IW;
  localparam int CHW = 5;
  localparam int CW  = $clog2(MAX_REPEATS + 1);
  localparam int XW  = SW + 16;
  localparam logic [CHW-1:0] CH_MAX = CHW'(MAX_CHANNELS);
  localparam logic [CW-1:0]  REP_MAX = CW'(MAX_REPEATS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACCUM, ST_SCALE, ST_RATE, ST_DIV, ST_EMIT
  } state_t;

  // Configuration registers
  logic [1:0]        fmt_r;
  logic [3:0]        chans_r;
  logic [RATE_W-1:0] in_rate_r, tgt_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= FMT_FLOAT32;
      chans_r    <= 4'd1;
      in_rate_r  <= RATE_W'(48000);
      tgt_rate_r <= RATE_W'(16000);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FORMAT:   fmt_r      <= cfg_wdata[1:0];
        REG_CHANNELS: chans_r    <= cfg_wdata[3:0];
        REG_IN_RATE:  in_rate_r  <= cfg_wdata;
        REG_TGT_RATE: tgt_rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective channel count and input rate
  logic [CHW-1:0]    ch_eff;
  logic [RATE_W-1:0] rin;
  always_comb begin
    if (chans_r == 4'd0) ch_eff = CHW'(1);
    else if (CHW'(chans_r) > CH_MAX) ch_eff = CH_MAX;
    else ch_eff = CHW'(chans_r);
    rin = (in_rate_r == '0) ? tgt_rate_r : in_rate_r;
  end

  // Convert one raw word to Q1.31
  function automatic logic signed [31:0] to_q31(input logic [31:0] w, input logic [1:0] f);
    logic [7:0]  e;
    logic [23:0] m;
    logic [7:0]  ex;
    logic [7:0]  sh;
    logic [31:0] mag;
    logic signed [31:0] res;
    e  = w[30:23];
    m  = {(e != 8'd0), w[22:0]};
    ex = (e != 8'd0) ? e : 8'd1;
    sh = 8'd119 - ex;
    if (e == 8'd255) mag = '0;
    else if (ex >= 8'd127) mag = 32'h8000_0000;
    else if (ex >= 8'd119) mag = {8'd0, m} << ex[2:0] - 3'd7;
    else if (sh >= 8'd24) mag = '0;
    else mag = {8'd0, m} >> sh[4:0];
    if (w[31]) res = -$signed(mag);
    else if (mag[31]) res = 32'sh7FFF_FFFF;
    else res = $signed(mag);
    if (f == FMT_INT16) res = $signed({w[15:0], 16'd0});
    else if (f == FMT_INT32) res = $signed(w);
    return res;
  endfunction

  state_t                state_r, state_nxt;
  logic [31:0]           word_r, word_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic signed [SW-1:0]  sum_r, sum_nxt;
  logic                  err_rep_r, err_rep_nxt;
  logic [DIV_W-1:0]      phase_r, phase_nxt;
  logic [DIV_W-1:0]      dq_r, dq_nxt;
  logic [DIV_W-1:0]      drem_r, drem_nxt;
  logic [RATE_W-1:0]     dd_r, dd_nxt;
  logic [4:0]            dcnt_r, dcnt_nxt;
  div_mode_t             dmode_r, dmode_nxt;
  logic                  neg_r, neg_nxt;
  logic [PCM_W-1:0]      pcm_r, pcm_nxt;
  logic                  err_r, err_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  // Datapath helpers
  logic signed [SW-1:0]  q31_ext;
  logic [SW-1:0]         mag;
  logic [XW-1:0]         xval;
  logic [DIV_W-1:0]      trial, rem_step;
  logic                  qbit;
  logic [DIV_W-1:0]      q_done;
  logic [DIV_W-1:0]      ph_sum;

  always_comb begin
    q31_ext  = SW'(to_q31(word_r, fmt_r));
    mag      = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
    xval     = (XW'(mag) << 15) - XW'(mag) + (XW'(ch_eff) << 30);
    trial    = {drem_r[DIV_W-2:0], dq_r[DIV_W-1]};
    qbit     = trial >= DIV_W'(dd_r);
    rem_step = qbit ? trial - DIV_W'(dd_r) : trial;
    q_done   = {dq_r[DIV_W-2:0], qbit};
    ph_sum   = phase_r + DIV_W'(tgt_rate_r);
  end

  always_comb begin
    state_nxt   = state_r;
    word_nxt    = word_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    err_rep_nxt = err_rep_r;
    phase_nxt   = phase_r;
    dq_nxt      = dq_r;
    drem_nxt    = drem_r;
    dd_nxt      = dd_r;
    dcnt_nxt    = dcnt_r;
    dmode_nxt   = dmode_r;
    neg_nxt     = neg_r;
    pcm_nxt     = pcm_r;
    err_nxt     = err_r;
    cnt_nxt     = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          word_nxt = in_tdata;
          if (in_tuser) begin
            idx_nxt   = '0;
            sum_nxt   = '0;
            pcm_nxt   = '0;
            err_nxt   = 1'b0;
            state_nxt = ST_RATE;
          end else if (fmt_r == FMT_BAD) begin
            if (!err_rep_r) begin
              err_rep_nxt = 1'b1;
              pcm_nxt     = '0;
              err_nxt     = 1'b1;
              cnt_nxt     = CW'(1);
              state_nxt   = ST_EMIT;
            end
          end else begin
            state_nxt = ST_ACCUM;
          end
        end
      end
      ST_ACCUM: begin
        sum_nxt = sum_r + q31_ext;
        if (CHW'(idx_r) + CHW'(1) < ch_eff) begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        // Mean with rounding: floor((mag*32767 + ch*2^30) / 2^31) / ch
        neg_nxt   = sum_r[SW-1];
        sum_nxt   = '0;
        dq_nxt    = DIV_W'(xval >> 31);
        drem_nxt  = '0;
        dd_nxt    = RATE_W'(ch_eff);
        dcnt_nxt  = '0;
        dmode_nxt = DIV_PCM;
        err_nxt   = 1'b0;
        state_nxt = ST_DIV;
      end
      ST_RATE: begin
        if (rin == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          dq_nxt    = ph_sum;
          drem_nxt  = '0;
          dd_nxt    = rin;
          dcnt_nxt  = '0;
          dmode_nxt = DIV_RATE;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle
        dq_nxt   = q_done;
        drem_nxt = rem_step;
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'(DIV_W - 1)) begin
          if (dmode_r == DIV_PCM) begin
            pcm_nxt   = (q_done > DIV_W'(PCM_MAX)) ? PCM_MAX : q_done[PCM_W-1:0];
            if (neg_r) pcm_nxt = -pcm_nxt;
            state_nxt = ST_RATE;
          end else begin
            phase_nxt = rem_step;
            cnt_nxt   = (q_done > DIV_W'(REP_MAX)) ? REP_MAX : CW'(q_done);
            state_nxt = (q_done == '0) ? ST_IDLE : ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      sum_r     <= '0;
      err_rep_r <= 1'b0;
      phase_r   <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
      err_rep_r <= err_rep_nxt;
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
    end
    word_r  <= word_nxt;
    dq_r    <= dq_nxt;
    drem_r  <= drem_nxt;
    dd_r    <= dd_nxt;
    dcnt_r  <= dcnt_nxt;
    dmode_r <= dmode_nxt;
    neg_r   <= neg_nxt;
    pcm_r   <= pcm_nxt;
    err_r   <= err_nxt;
  end

  // Drive the ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = pcm_r;
  assign out_tuser  = err_r;
  assign out_tlast  = (cnt_r == CW'(1));

endmodule

>>> tb/tb_audio_downmix_resample_pcm16_top.sv
// Self-checking testbench for the mono downmix and drop/repeat rate converter.
module tb_audio_downmix_resample_pcm16_top;
  import adrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CH  = 8;
  localparam int MAX_REP = 64;
  localparam int SETTLE  = 64;

  typedef struct packed {
    logic [15:0] pcm;
    logic        err;
    logic        last;
  } pcm_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [18:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] sample_word
  logic        in_tuser;   // [0] silent
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] pcm_sample
  logic        out_tuser;  // [0] error
  logic        out_tlast;

  audio_downmix_resample_pcm16_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Shadow of the configuration and of the block state
  logic [1:0]  fmt_sh;
  logic [3:0]  chans_sh;
  logic [18:0] rin_sh;
  logic [18:0] tgt_sh;
  longint unsigned phase_acc;
  int          chan_pos;
  longint      mix_sum;
  bit          err_sent;

  pcm_result_t pcm_expected_q[$];
  int          mismatches;
  int          items_sent;
  int          results_seen;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // Convert a float32 word to Q1.31, truncating toward zero
  function automatic longint float_q31(logic [31:0] w);
    longint unsigned m;
    longint unsigned mag;
    int              ex;
    int              sh;
    if (w[30:23] == 8'hFF) return 0;
    m = w[22:0];
    if (w[30:23] != 8'h00) begin
      m = m | 64'h80_0000;
      ex = w[30:23];
    end else begin
      ex = 1;
    end
    if (ex >= 127) begin
      mag = 64'h8000_0000;
    end else if (ex >= 119) begin
      mag = m << (ex - 119);
    end else begin
      sh = 119 - ex;
      mag = (sh >= 32) ? 0 : (m >> sh);
    end
    if (w[31]) return -longint'(mag);
    return (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(mag);
  endfunction

  function automatic longint channel_q31(logic [31:0] w);
    case (fmt_sh)
      FMT_FLOAT32: return float_q31(w);
      FMT_INT16:   return longint'($signed(w[15:0])) * 65536;
      default:     return longint'($signed(w));
    endcase
  endfunction

  // Mean of the frame scaled to 16 bits, rounded half away from zero
  function automatic logic [15:0] mean_to_pcm(longint s, int ch);
    longint unsigned mag;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    num = mag * 32767;
    den = longint'(ch) << 31;
    q = (2 * num + den) / (2 * den);
    if (q > 32767) q = 32767;
    return (s < 0) ? 16'(-int'(q)) : 16'(q);
  endfunction

  // Advance the phase and queue each repeat of the sample
  task automatic rate_convert(logic [15:0] pcm);
    longint unsigned rin;
    longint unsigned n;
    pcm_result_t     r;
    rin = (rin_sh == 0) ? tgt_sh : rin_sh;
    if (rin == 0) return;
    phase_acc = phase_acc + tgt_sh;
    n = phase_acc / rin;
    phase_acc = phase_acc % rin;
    if (n > MAX_REP) n = MAX_REP;
    for (int k = 0; k < n; k++) begin
      r.pcm = pcm;
      r.err = 1'b0;
      r.last = (k + 1 == n);
      pcm_expected_q = {pcm_expected_q, r};
    end
  endtask

  task automatic predict_item(logic [31:0] word, logic silent);
    int          ch;
    pcm_result_t r;
    ch = (chans_sh == 0) ? 1 : chans_sh;
    if (ch > MAX_CH) ch = MAX_CH;
    if (silent) begin
      chan_pos = 0;
      mix_sum = 0;
      rate_convert(16'd0);
    end else if (fmt_sh == FMT_BAD) begin
      if (!err_sent) begin
        err_sent = 1'b1;
        r.pcm = 16'd0;
        r.err = 1'b1;
        r.last = 1'b1;
        pcm_expected_q = {pcm_expected_q, r};
      end
    end else begin
      mix_sum = mix_sum + channel_q31(word);
      if (chan_pos + 1 < ch) begin
        chan_pos++;
      end else begin
        chan_pos = 0;
        rate_convert(mean_to_pcm(mix_sum, ch));
        mix_sum = 0;
      end
    end
  endtask

  // Offer one item, optionally after a gap; valid stays high afterwards
  task automatic send_item(logic [31:0] word, logic silent);
    int gap;
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= silent;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(word, silent);
    items_sent++;
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  // Wait for all expected results plus the tail of a resultless item
  task automatic wait_drain();
    while (pcm_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [18:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_FORMAT:   fmt_sh = val[1:0];
      REG_CHANNELS: chans_sh = val[3:0];
      REG_IN_RATE:  rin_sh = val;
      default:      tgt_sh = val;
    endcase
  endtask

  task automatic set_config(logic [1:0] f, logic [3:0] ch, logic [18:0] rin, logic [18:0] tgt);
    write_reg(REG_FORMAT, {17'd0, f});
    write_reg(REG_CHANNELS, {15'd0, ch});
    write_reg(REG_IN_RATE, rin);
    write_reg(REG_TGT_RATE, tgt);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    pcm_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pcm_expected_q.size() == 0) begin
        $display("%0t: result expected none actual pcm=%0d err=%0b last=%0b", $realtime,
                 $signed(out_tdata), out_tuser, out_tlast);
        mismatches++;
      end else begin
        e = pcm_expected_q.pop_front();
        if (out_tdata !== e.pcm) begin
          $display("%0t: pcm expected %0d actual %0d", $realtime, $signed(e.pcm),
                   $signed(out_tdata));
          mismatches++;
        end
        if (out_tuser !== e.err) begin
          $display("%0t: error expected %0b actual %0b", $realtime, e.err, out_tuser);
          mismatches++;
        end
        if (out_tlast !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $realtime, e.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Drive ready at random; hold it low while a hold-off is counting
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Float extremes under the reset configuration (1 channel, 48k to 16k)
  task automatic test_float_defaults();
    logic [31:0] words[12] = '{32'h0000_0000, 32'h3F80_0000, 32'hBF80_0000,
                               32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000,
                               32'h0000_0001, 32'h3F00_0000, 32'h7F7F_FFFF,
                               32'hFF7F_FFFF, 32'h8000_0000, 32'h3F7F_FFFF};
    foreach (words[i]) send_item(words[i], 1'b0);
    end_burst();
    wait_drain();
  endtask

  // Integer formats, channel count extremes and silence mid-frame
  task automatic test_int_formats();
    set_config(FMT_INT16, 4'd2, 19'd8000, 19'd8000);
    send_item(32'h0000_7FFF, 1'b0);
    send_item(32'hFFFF_7FFF, 1'b0);
    send_item(32'h0000_8000, 1'b0);
    send_item(32'h1234_8000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    end_burst();
    wait_drain();
    set_config(FMT_INT32, 4'd0, 19'd0, 19'd22050);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    end_burst();
    wait_drain();
    set_config(FMT_INT32, 4'd15, 19'd44100, 19'd44100);
    for (int i = 0; i < 8; i++) send_item(32'h8000_0000, 1'b0);
    for (int i = 0; i < 8; i++) send_item(32'h7FFF_FFFF, 1'b0);
    end_burst();
    wait_drain();
  endtask

  // Unsupported format, zero rates, repeat cap and heavy drop
  task automatic test_special_rates();
    set_config(FMT_BAD, 4'd1, 19'd16000, 19'd16000);
    send_item(32'hDEAD_BEEF, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    end_burst();
    wait_drain();
    set_config(FMT_INT16, 4'd1, 19'd0, 19'd0);
    send_item(32'h0000_1234, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    end_burst();
    wait_drain();
    set_config(FMT_INT16, 4'd1, 19'd1000, 19'd524287);
    send_item(32'h0000_4000, 1'b0);
    end_burst();
    wait_drain();
    set_config(FMT_INT16, 4'd1, 19'd8000, 19'd512000);
    send_item(32'h0000_C000, 1'b0);
    end_burst();
    wait_drain();
    set_config(FMT_FLOAT32, 4'd1, 19'd524287, 19'd1);
    send_item(32'h3E80_0000, 1'b0);
    end_burst();
    wait_drain();
  endtask

  // Stall the output long enough to back up the input, then pause for drain
  task automatic test_backpressure();
    set_config(FMT_INT16, 4'd1, 19'd4000, 19'd16000);
    hold_left = 500;
    for (int i = 0; i < 12; i++) send_item($urandom, 1'b0);
    end_burst();
    wait_drain();
  endtask

  // Random configurations and mostly well-formed frames
  task automatic test_random_phase(int n_items);
    logic [18:0] rin;
    logic [18:0] tgt;
    logic [31:0] w;
    int          left;
    left = n_items;
    while (left > 0) begin
      rin = 19'($urandom_range(1, 96000));
      tgt = 19'($urandom_range(1, (rin * 3 > 524287) ? 524287 : rin * 3));
      if ($urandom_range(9) == 0) rin = 19'd0;
      set_config(($urandom_range(19) == 0) ? FMT_BAD : 2'($urandom_range(2)),
                 4'($urandom_range(15)), rin, tgt);
      for (int i = 0; i < 12 && left > 0; i++) begin
        case ($urandom_range(3))
          0: w = $urandom;
          1: w = {1'($urandom_range(1)), 8'($urandom_range(110, 128)), 23'($urandom)};
          default: w = $urandom;
        endcase
        send_item(w, $urandom_range(11) == 0);
        left--;
      end
      end_burst();
      wait_drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_FORMAT;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    hold_left = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    fmt_sh = FMT_FLOAT32;
    chans_sh = 4'd1;
    rin_sh = 19'd48000;
    tgt_sh = 19'd16000;
    phase_acc = 0;
    chan_pos = 0;
    mix_sum = 0;
    err_sent = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_float_defaults();
    test_int_formats();
    test_special_rates();
    test_backpressure();
    snd_idle_pct = 6;
    rcv_idle_pct = 53;
    test_random_phase(15);
    snd_idle_pct = 53;
    rcv_idle_pct = 6;
    test_random_phase(15);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_phase(15);

    $display("Covered float/int16/int32 and unsupported formats, silence, channel and rate");
    $display("extremes, output stall: %0d items, %0d results", items_sent, results_seen);
    if (mismatches == 0 && pcm_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
